/* rtl/tmma_pkg.sv */
// Shared types and codes for the tile multiply-accumulate block.
`default_nettype none
package tmma_pkg;

  localparam logic [2:0] MODE_LOAD_A = 3'd0;
  localparam logic [2:0] MODE_LOAD_B = 3'd1;
  localparam logic [2:0] MODE_LOAD_R = 3'd2;
  localparam logic [2:0] MODE_MAC    = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_LOAD_R,
    OP_MAC,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic               in_grid;
    logic signed [31:0] ab_value;
    logic signed [63:0] acc_value;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/tmma_front.sv */
// Front end: accepts requests, classifies them and queues commands.
`default_nettype none
module tmma_front #(
  parameter int TILE_MAX = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         in_mode,
  input  wire logic [3:0]         in_row,
  input  wire logic [3:0]         in_col,
  input  wire logic signed [31:0] in_ab_value,
  input  wire logic signed [63:0] in_acc_value,
  output logic                    cmd_valid,
  output tmma_pkg::cmd_t          cmd,
  input  wire logic               cmd_pop
);
  import tmma_pkg::*;

  cmd_t       q_r [CMDQ_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       in_grid;
  logic       keep;
  logic       accept;
  cmd_t       new_cmd;

  always_comb begin
    in_grid = (32'(in_row) < TILE_MAX) && (32'(in_col) < TILE_MAX);
    new_cmd.row       = in_row;
    new_cmd.col       = in_col;
    new_cmd.in_grid   = in_grid;
    new_cmd.ab_value  = in_ab_value;
    new_cmd.acc_value = in_acc_value;
    new_cmd.op        = OP_MAC;
    keep              = 1'b0;
    unique case (in_mode)
      MODE_LOAD_A: begin
        new_cmd.op = OP_LOAD_A;
        keep       = in_grid;
      end
      MODE_LOAD_B: begin
        new_cmd.op = OP_LOAD_B;
        keep       = in_grid;
      end
      MODE_LOAD_R: begin
        new_cmd.op = OP_LOAD_R;
        keep       = in_grid;
      end
      MODE_MAC: begin
        new_cmd.op = OP_MAC;
        keep       = 1'b1;
      end
      MODE_READ: begin
        new_cmd.op = OP_READ;
        keep       = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full      = (cnt_r == 2'(CMDQ_DEPTH));
  assign accept    = push && !full && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(accept) - 2'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/tmma_back.sv */
// Back end: tile memories, clearing pass and multiply-accumulate sequencer.
`default_nettype none
module tmma_back #(
  parameter int TILE_MAX = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [4:0]         dim,
  input  wire logic               cmd_valid,
  input  wire tmma_pkg::cmd_t     cmd,
  output logic                    cmd_pop,
  input  wire logic [1:0]         out_cnt,
  output logic                    out_push,
  output logic signed [63:0]      out_data
);
  import tmma_pkg::*;

  localparam int IDX_W = $clog2(TILE_MAX);
  localparam int AW    = 2 * IDX_W;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_WR
  } state_t;

  state_t             state_r;
  logic [AW-1:0]      clr_r;
  logic [IDX_W-1:0]   i_r, k_r, j_r;
  logic               rd_pend_r;
  logic               rd_zero_r;

  logic signed [31:0] a_mem [DEPTH];
  logic signed [31:0] b_mem [DEPTH];
  logic signed [63:0] r_mem [DEPTH];
  logic signed [31:0] a_q_r, b_q_r;
  logic signed [63:0] r_q_r;
  logic signed [63:0] prod_r;

  logic [IDX_W:0]     n;
  logic [31:0]        row32, col32;
  logic [AW-1:0]      cmd_addr;
  logic [AW-1:0]      r_rd_addr;
  logic               r_we;
  logic [AW-1:0]      r_wa;
  logic signed [63:0] r_wd;
  logic signed [64:0] sum_w;
  logic signed [63:0] sat_w;
  logic               room;
  logic               last_j, last_k, last_i;

  assign n = (32'(dim) >= TILE_MAX) ? (IDX_W+1)'(TILE_MAX) : (IDX_W+1)'(dim);
  assign row32    = 32'(cmd.row);
  assign col32    = 32'(cmd.col);
  assign cmd_addr = {row32[IDX_W-1:0], col32[IDX_W-1:0]};
  assign room     = ({1'b0, out_cnt} + {2'b0, rd_pend_r}) < 3'(OUTQ_DEPTH);
  assign cmd_pop  = (state_r == ST_RUN) && cmd_valid && ((cmd.op != OP_READ) || room);
  assign r_rd_addr = (state_r == ST_RUN) ? cmd_addr : {i_r, j_r};

  assign last_j = ({1'b0, j_r} == n - 1'b1);
  assign last_k = ({1'b0, k_r} == n - 1'b1);
  assign last_i = ({1'b0, i_r} == n - 1'b1);

  always_comb begin
    sum_w = {r_q_r[63], r_q_r} + {prod_r[63], prod_r};
    if (sum_w[64] != sum_w[63]) begin
      sat_w = sum_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_w = sum_w[63:0];
    end
  end

  always_comb begin
    r_we = 1'b0;
    r_wa = {i_r, j_r};
    r_wd = sat_w;
    priority if (state_r == ST_CLEAR) begin
      r_we = 1'b1;
      r_wa = clr_r;
      r_wd = 64'sd0;
    end else if (state_r == ST_MAC_WR) begin
      r_we = 1'b1;
    end else if (cmd_pop && cmd.op == OP_LOAD_R) begin
      r_we = 1'b1;
      r_wa = cmd_addr;
      r_wd = cmd.acc_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_LOAD_A) begin
      a_mem[cmd_addr] <= cmd.ab_value;
    end
    if (cmd_pop && cmd.op == OP_LOAD_B) begin
      b_mem[cmd_addr] <= cmd.ab_value;
    end
    if (r_we) begin
      r_mem[r_wa] <= r_wd;
    end
    a_q_r <= a_mem[{i_r, k_r}];
    b_q_r <= b_mem[{k_r, j_r}];
    r_q_r <= r_mem[r_rd_addr];
  end

  always_ff @(posedge clk) begin
    prod_r <= a_q_r * b_q_r;
  end

  assign out_push = rd_pend_r;
  assign out_data = rd_zero_r ? 64'sd0 : r_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      i_r       <= '0;
      k_r       <= '0;
      j_r       <= '0;
      rd_pend_r <= 1'b0;
      rd_zero_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd_pop && (cmd.op == OP_READ);
      rd_zero_r <= !cmd.in_grid;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH - 1)) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cmd_pop && cmd.op == OP_MAC && n != '0) begin
            i_r     <= '0;
            k_r     <= '0;
            j_r     <= '0;
            state_r <= ST_MAC_RD;
          end
        end
        ST_MAC_RD:  state_r <= ST_MAC_MUL;
        ST_MAC_MUL: state_r <= ST_MAC_WR;
        ST_MAC_WR: begin
          state_r <= ST_MAC_RD;
          if (!last_j) begin
            j_r <= j_r + 1'b1;
          end else begin
            j_r <= '0;
            if (!last_k) begin
              k_r <= k_r + 1'b1;
            end else begin
              k_r <= '0;
              if (!last_i) begin
                i_r <= i_r + 1'b1;
              end else begin
                i_r     <= '0;
                state_r <= ST_RUN;
              end
            end
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/tmma_out_queue.sv */
// Result queue between the back end and the result channel.
`default_nettype none
module tmma_out_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic signed [63:0] wr_data,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [63:0]      rd_data,
  output logic [1:0]              cnt
);
  import tmma_pkg::*;

  logic signed [63:0] q_r [OUTQ_DEPTH];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         cnt_r;
  logic               take;

  assign empty   = (cnt_r == 2'd0);
  assign take    = pop && !empty;
  assign rd_data = q_r[rd_ptr_r];
  assign cnt     = cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (take) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(wr_en) - 2'(take);
    end
  end

endmodule
`default_nettype wire

/* rtl/tile_matrix_multiply_accumulate.sv */
// Top level of the tile multiply-accumulate block, R += A*B.
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+-------------
//  request  | in_mode in_row in_col in_ab_value in_acc_value | push / full
//  result   | out_acc_out                                    | empty / pop
//  config   | cfg_dim                                        | cfg_wr_en
//
// The back end can take a new load or read before the last one is through; a
// read result is registered from R with a pending flag, then queued.
// A multiply-accumulate runs n^3 steps, n = min(dim, TILE_MAX), through
// one shared multiplier, one R read and one R write port: read, multiply, add per step.
// After reset a clearing pass writes R to zero, TILE_MAX^2 entries (rounded up
// to a power of two squared), while requests only queue.
// Two-entry queues sit between front, back and result ports; a held pop
// backs up reads, then the request queue, then full.
`default_nettype none
module tile_matrix_multiply_accumulate #(
  parameter int TILE_MAX = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         in_mode,
  input  wire logic [3:0]         in_row,
  input  wire logic [3:0]         in_col,
  input  wire logic signed [31:0] in_ab_value,
  input  wire logic signed [63:0] in_acc_value,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [63:0]      out_acc_out,
  input  wire logic               cfg_wr_en,
  input  wire logic [4:0]         cfg_dim
);
  import tmma_pkg::*;

  logic [4:0]         dim_r;
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;
  logic [1:0]         out_cnt;
  logic               out_push;
  logic signed [63:0] out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= 5'd16;
    end else if (cfg_wr_en) begin
      dim_r <= cfg_dim;
    end
  end

  tmma_front #(.TILE_MAX(TILE_MAX)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_mode      (in_mode),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_ab_value  (in_ab_value),
    .in_acc_value (in_acc_value),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  tmma_back #(.TILE_MAX(TILE_MAX)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dim       (dim_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_cnt   (out_cnt),
    .out_push  (out_push),
    .out_data  (out_data)
  );

  tmma_out_queue u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_push),
    .wr_data (out_data),
    .empty   (empty),
    .pop     (pop),
    .rd_data (out_acc_out),
    .cnt     (out_cnt)
  );

  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (out_cnt != 2'(OUTQ_DEPTH)) || (pop && !empty))
    else $error("result queue overflow");

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd.op == OP_READ) |=> out_push)
    else $error("read request lost");

endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for the tile multiply-accumulate block: scoreboarded loads, MACs and R reads.
`default_nettype none
module tb;
  import tmma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID = 16;
  localparam int STALL_LIMIT = 60000;
  localparam logic [2:0] MODE_LAST = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [2:0] in_mode = MODE_LOAD_A;
  logic [3:0] in_row = '0;
  logic [3:0] in_col = '0;
  logic signed [31:0] in_ab_value = '0;
  logic signed [63:0] in_acc_value = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [63:0] out_acc_out;
  logic cfg_wr_en = 1'b0;
  logic [4:0] cfg_dim = 5'd16;

  tile_matrix_multiply_accumulate dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_mode(in_mode), .in_row(in_row), .in_col(in_col),
    .in_ab_value(in_ab_value), .in_acc_value(in_acc_value),
    .empty(empty), .pop(pop), .out_acc_out(out_acc_out),
    .cfg_wr_en(cfg_wr_en), .cfg_dim(cfg_dim)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] a_mem [GRID][GRID];
  logic signed [31:0] b_mem [GRID][GRID];
  logic signed [63:0] r_mem [GRID][GRID] = '{default: '0};
  bit a_set [GRID][GRID];
  bit b_set [GRID][GRID];
  int tile_n = 16;
  logic signed [63:0] pending_reads [$];
  int errors = 0;
  bit calm = 1'b0;
  int send_gap = 0;

  function automatic logic signed [63:0] sat_sum(logic signed [63:0] x, logic signed [63:0] y);
    logic signed [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  task automatic mac_predict();
    logic signed [63:0] prod;
    for (int i = 0; i < tile_n; i++)
      for (int k = 0; k < tile_n; k++)
        for (int j = 0; j < tile_n; j++) begin
          prod = a_mem[i][k] * b_mem[k][j];
          r_mem[i][j] = sat_sum(r_mem[i][j], prod);
        end
  endtask

  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 3) << 16));
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic signed [63:0] pick_q32();
    case ($urandom_range(0, 5))
      0: return {1'b0, {63{1'b1}}};
      1: return {1'b1, 63'd0};
      2: return 64'sd0;
      default: return $signed({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_req(logic [2:0] mode, logic [3:0] row, logic [3:0] col,
                          logic signed [31:0] abv, logic signed [63:0] accv);
    repeat (send_gap) @(posedge clk);
    push <= 1'b1;
    in_mode <= mode;
    in_row <= row;
    in_col <= col;
    in_ab_value <= abv;
    in_acc_value <= accv;
    @(posedge clk);
    while (full) @(posedge clk);
    case (mode)
      MODE_LOAD_A: begin a_mem[row][col] = abv; a_set[row][col] = 1'b1; end
      MODE_LOAD_B: begin b_mem[row][col] = abv; b_set[row][col] = 1'b1; end
      MODE_LOAD_R: r_mem[row][col] = accv;
      MODE_MAC:    mac_predict();
      MODE_READ:   pending_reads.push_back(r_mem[row][col]);
      default: ;
    endcase
    send_gap = calm ? 0 : $urandom_range(0, 4);
    if (send_gap > 0) push <= 1'b0;
  endtask

  task automatic fill_missing();
    for (int r = 0; r < tile_n; r++)
      for (int c = 0; c < tile_n; c++) begin
        if (!a_set[r][c]) send_req(MODE_LOAD_A, r, c, pick_q16(), '0);
        if (!b_set[r][c]) send_req(MODE_LOAD_B, r, c, pick_q16(), '0);
      end
  endtask

  task automatic run_mac();
    fill_missing();
    send_req(MODE_MAC, '0, '0, '0, '0);
  endtask

  // a trailing read retires behind any MAC, so its result marks the block idle
  task automatic quiesce();
    send_req(MODE_READ, $urandom, $urandom, '0, '0);
    if (send_gap == 0) push <= 1'b0;
    send_gap = 1;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_dim(logic [4:0] v);
    quiesce();
    cfg_wr_en <= 1'b1;
    cfg_dim <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tile_n = (v > GRID) ? GRID : v;
  endtask

  // result checker with random pop stalls
  int pop_wait = 0;
  always @(posedge clk) begin
    logic pop_next;
    logic signed [63:0] want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (pending_reads.size() == 0) begin
          $display("%0t: unexpected result acc_out=%h", $time, out_acc_out);
          errors++;
        end else begin
          want = pending_reads.pop_front();
          if (out_acc_out !== want) begin
            $display("%0t: acc_out mismatch expected %h actual %h", $time, want, out_acc_out);
            errors++;
          end
        end
        pop_wait = calm ? 0 : $urandom_range(0, 4);
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop_next = 1'b0;
      end else pop_next = 1'b1;
      pop <= pop_next;
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_reset_state();
    for (int i = 0; i < 4; i++) send_req(MODE_READ, $urandom, $urandom, '0, '0);
    send_req(MODE_READ, 4'd15, 4'd15, '0, '0);
  endtask

  task automatic test_extremes();
    set_dim(5'd2);
    send_req(MODE_LOAD_A, 0, 0, 32'sh7fffffff, '0);
    send_req(MODE_LOAD_A, 0, 1, 32'sh7fffffff, '0);
    send_req(MODE_LOAD_A, 1, 0, 32'sh80000000, '0);
    send_req(MODE_LOAD_A, 1, 1, 32'sh80000000, '0);
    send_req(MODE_LOAD_B, 0, 0, 32'sh7fffffff, '0);
    send_req(MODE_LOAD_B, 0, 1, 32'sh80000000, '0);
    send_req(MODE_LOAD_B, 1, 0, 32'sh7fffffff, '0);
    send_req(MODE_LOAD_B, 1, 1, 32'sh80000000, '0);
    send_req(MODE_LOAD_R, 0, 0, 32'sh7fffffff, {1'b0, {63{1'b1}}});
    send_req(MODE_LOAD_R, 0, 1, '0, {1'b1, 63'd0});
    send_req(MODE_LOAD_R, 1, 0, '0, {1'b1, 63'd0});
    send_req(MODE_LOAD_R, 15, 15, '1, 64'sh0123456789abcdef);
    run_mac();
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++) send_req(MODE_READ, r, c, '0, '0);
    send_req(MODE_READ, 15, 15, '0, '0);
    for (int m = MODE_READ + 1; m <= MODE_LAST; m++) send_req(m, 0, 0, '1, '1);
    send_req(MODE_READ, 0, 0, '0, '0);
  endtask

  task automatic test_size_corners();
    set_dim(5'd0);
    run_mac();
    send_req(MODE_READ, 0, 0, '0, '0);
    set_dim(5'd31);
    run_mac();
    send_req(MODE_READ, 15, 15, '0, '0);
    send_req(MODE_READ, 3, 9, '0, '0);
    set_dim(5'd1);
    run_mac();
    send_req(MODE_READ, 0, 0, '0, '0);
  endtask

  task automatic test_random();
    int roll;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 7) set_dim(5'd16);
      else set_dim($urandom_range(0, 6));
      calm = (ph % 4 == 3);
      for (int it = 0; it < 200; it++) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) send_req(MODE_LOAD_A, $urandom, $urandom, pick_q16(), pick_q32());
        else if (roll < 50) send_req(MODE_LOAD_B, $urandom, $urandom, pick_q16(), pick_q32());
        else if (roll < 62) send_req(MODE_LOAD_R, $urandom, $urandom, pick_q16(), pick_q32());
        else if (roll < 66 && (ph != 7 || it % 100 == 99)) run_mac();
        else if (roll < 96) send_req(MODE_READ, $urandom_range(0, 7), $urandom_range(0, 7),
                                     pick_q16(), pick_q32());
        else send_req($urandom_range(MODE_READ + 1, MODE_LAST), $urandom, $urandom,
                      pick_q16(), pick_q32());
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_extremes();
    test_size_corners();
    test_random();
    quiesce();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
